>>> rtl/bstk_pkg.sv
// Stack package: widths, defaults, APB map, request/status codes, sequencer states.
`default_nettype none
package bstk_pkg;

  // Fixed field widths
  localparam int DATA_W = 32;
  localparam int OCC_W  = 7;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  // Storage defaults
  localparam int DEPTH_DEFAULT = 64;
  localparam logic [OCC_W-1:0] CAP_RESET = 7'd64;

  // APB register map
  localparam int APB_AW = 3;
  localparam logic REG_CAPACITY = 1'b0;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DEL  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PEEK = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLR  = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_RD,
    S_EMIT,
    S_DEL,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> rtl/bstk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bstk_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/bounded_stack_with_bulk_ops.sv
// Top level of the bounded LIFO stack with bulk push, pop, delete, peek and clear.
`default_nettype none
// The stack words live in one RAM with a registered read port. A small
// sequencer works one request at a time, and in_stall stays high until the last
// result beat of that request is in the output register. Push writes one word
// per cycle until count is done or the stack fills, then sends the closing beat
// and goes back to idle. Pop and peek read one word and then load it into the
// output register, for each returned word; a beat waits while out_stall holds
// the output register. Delete streams the store bottom to top through the read
// port while the write port compacts the survivors, then sends the closing beat.
// Clear, unused codes and pop or peek that return nothing go straight to the
// closing beat. The output register lets a new request enter while the last
// result still waits to be taken. No clearing pass after reset: only entries
// below the occupancy are ever read.
module bounded_stack_with_bulk_ops
  import bstk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // request channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [REQ_W-1:0]         req_type,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic [OCC_W-1:0]         count,
  input  wire logic                     all_flag,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      data,
  output logic [STAT_W-1:0]             status,
  output logic [OCC_W-1:0]              in_use,
  output logic                          last,
  // APB configuration
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_AW-1:0]        paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

  state_t state, state_next;

  logic [OCC_W-1:0]  capacity;
  logic [OCC_W-1:0]  limit;
  logic [OCC_W-1:0]  occ, occ_next;
  logic [OCC_W-1:0]  rem, rem_next;
  logic [OCC_W-1:0]  ptr, ptr_next;
  logic [OCC_W-1:0]  rd_idx, rd_idx_next;
  logic [OCC_W-1:0]  dst, dst_next;
  logic [OCC_W-1:0]  removed, removed_next;
  logic [OCC_W-1:0]  lim, lim_next;
  logic              pend, pend_next;
  logic              is_pop, is_pop_next;
  logic [DATA_W-1:0] val_q, val_q_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic [OCC_W-1:0]  n_sel;

  logic                     out_valid_next;
  logic signed [DATA_W-1:0] data_next;
  logic [STAT_W-1:0]        status_next;
  logic [OCC_W-1:0]         in_use_next;
  logic                     last_next;
  logic                     out_free;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] rd_data;

  // Stack storage
  bstk_ram #(
    .WIDTH  (DATA_W),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // APB: single capacity register, pready tied high
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1:2] == REG_CAPACITY) ? {25'b0, capacity} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[APB_AW-1:2] == REG_CAPACITY)) begin
      capacity <= pwdata[OCC_W-1:0];
    end
  end

  // Usable entries, saturated at the RAM depth
  assign limit = (capacity > DEPTH_OCC) ? DEPTH_OCC : capacity;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign n_sel    = all_flag ? occ : ((count > occ) ? occ : count);

  // Sequencer: next state, RAM controls, output register loads
  always_comb begin
    state_next      = state;
    occ_next        = occ;
    rem_next        = rem;
    ptr_next        = ptr;
    rd_idx_next     = rd_idx;
    dst_next        = dst;
    removed_next    = removed;
    lim_next        = lim;
    pend_next       = pend;
    is_pop_next     = is_pop;
    val_q_next      = val_q;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_waddr       = occ[AW-1:0];
    mem_wdata       = val_q;
    mem_re          = 1'b0;
    mem_raddr       = ptr[AW-1:0];
    out_valid_next  = out_valid && out_stall;
    data_next       = data;
    status_next     = status;
    in_use_next     = in_use;
    last_next       = last;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          val_q_next      = value;
          rem_next        = count;
          is_pop_next     = (req_type == REQ_POP);
          res_status_next = ST_OK;
          unique case (req_type) inside
            REQ_PUSH: begin
              state_next = S_PUSH;
            end
            REQ_POP, REQ_PEEK: begin
              if (occ == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_DONE;
              end else if (n_sel == '0) begin
                state_next = S_DONE;
              end else begin
                rem_next   = n_sel;
                ptr_next   = occ - 1'b1;
                state_next = S_RD;
              end
            end
            REQ_DEL: begin
              rd_idx_next  = '0;
              dst_next     = '0;
              removed_next = '0;
              pend_next    = 1'b0;
              lim_next     = all_flag ? occ : count;
              state_next   = S_DEL;
            end
            REQ_CLR: begin
              occ_next   = '0;
              state_next = S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      // One word per cycle until count is done or the stack fills
      S_PUSH: begin
        if (rem == '0) begin
          state_next = S_DONE;
        end else if (occ < limit) begin
          mem_we    = 1'b1;
          mem_waddr = occ[AW-1:0];
          mem_wdata = val_q;
          occ_next  = occ + 1'b1;
          rem_next  = rem - 1'b1;
        end else begin
          res_status_next = ST_FULL;
          state_next      = S_DONE;
        end
      end

      S_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = ptr[AW-1:0];
        state_next = S_EMIT;
      end

      // Pop/peek beat; read data holds until the output register is free
      S_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          data_next      = $signed(rd_data);
          status_next    = ST_OK;
          in_use_next    = is_pop ? occ - 1'b1 : occ;
          last_next      = (rem == 7'd1);
          if (is_pop) begin
            occ_next = occ - 1'b1;
          end
          rem_next   = rem - 1'b1;
          ptr_next   = ptr - 1'b1;
          state_next = (rem == 7'd1) ? S_IDLE : S_RD;
        end
      end

      // Streaming compaction: read entry i, write survivor of i-1 at dst
      S_DEL: begin
        if (rd_idx < occ) begin
          mem_re      = 1'b1;
          mem_raddr   = rd_idx[AW-1:0];
          rd_idx_next = rd_idx + 1'b1;
          pend_next   = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          if ((removed < lim) && (rd_data == val_q)) begin
            removed_next = removed + 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = dst[AW-1:0];
            mem_wdata = rd_data;
            dst_next  = dst + 1'b1;
          end
        end
        if ((rd_idx == occ) && !pend) begin
          occ_next   = dst;
          state_next = S_DONE;
        end
      end

      // Single closing beat
      S_DONE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          data_next      = '0;
          status_next    = res_status;
          in_use_next    = occ;
          last_next      = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      out_valid <= out_valid_next;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    rem        <= rem_next;
    ptr        <= ptr_next;
    rd_idx     <= rd_idx_next;
    dst        <= dst_next;
    removed    <= removed_next;
    lim        <= lim_next;
    pend       <= pend_next;
    is_pop     <= is_pop_next;
    val_q      <= val_q_next;
    res_status <= res_status_next;
    data       <= data_next;
    status     <= status_next;
    in_use     <= in_use_next;
    last       <= last_next;
  end

`ifndef SYNTHESIS
  // Occupancy never runs past the RAM depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= DEPTH_OCC)
    else $error("occupancy exceeds depth");

  // A request in flight blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  // An empty report always shows an empty stack
  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> in_use == '0 && last)
    else $error("empty status with entries held");

  // Full is only reported once the usable limit is reached
  a_full_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> in_use >= limit)
    else $error("full status below limit");
`endif

endmodule
`default_nettype wire

>>> test/bounded_stack_with_bulk_ops_tb.sv
// Self-checking testbench for the bounded stack: directed table, random phases, shadow stack.
`timescale 1ns / 1ps
module bounded_stack_with_bulk_ops_tb
  import bstk_pkg::*;
();

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam logic [APB_AW-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
  localparam int NUM_DIRECTED = 25;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 41;

  // one result beat
  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         in_use;
    logic                     last;
  } stack_beat_t;

  // directed row; lit rows carry a single literal result (data 0, last 1)
  typedef struct packed {
    logic [REQ_W-1:0]         rq;
    logic signed [DATA_W-1:0] v;
    logic [OCC_W-1:0]         c;
    logic                     a;
    logic                     lit;
    logic [STAT_W-1:0]        st;
    logic [OCC_W-1:0]         iu;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [REQ_W-1:0] req_type;
  logic signed [DATA_W-1:0] value;
  logic [OCC_W-1:0] count;
  logic all_flag;
  logic out_valid;
  logic out_stall;
  logic signed [DATA_W-1:0] data;
  logic [STAT_W-1:0] status;
  logic [OCC_W-1:0] in_use;
  logic last;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bounded_stack_with_bulk_ops uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .value(value), .count(count), .all_flag(all_flag),
    .out_valid(out_valid), .out_stall(out_stall),
    .data(data), .status(status), .in_use(in_use), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the stack
  logic signed [DATA_W-1:0] shadow_words [DEPTH];
  int shadow_occ;
  int shadow_cap;

  stack_beat_t pending_beats [$];
  stack_beat_t got_beat;
  int mismatches = 0;
  int idle_pct = 20;
  bit quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void queue_beat(input logic signed [DATA_W-1:0] d,
                                     input logic [STAT_W-1:0] st, input logic lst);
    stack_beat_t b;
    b.data = d;
    b.status = st;
    b.in_use = OCC_W'(shadow_occ);
    b.last = lst;
    pending_beats.push_back(b);
  endfunction

  // predict the beats of one accepted request and update the shadow stack
  task automatic model_request(input logic [REQ_W-1:0] rq, input logic signed [DATA_W-1:0] v,
                               input logic [OCC_W-1:0] c, input logic a, output int nres);
    int lim, n, quota, removed, dst, i, before_sz;
    logic full;
    before_sz = pending_beats.size();
    lim = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    case (rq) inside
      REQ_PUSH: begin
        full = 1'b0;
        for (i = 0; i < int'(c); i++) begin
          if (shadow_occ < lim) begin
            shadow_words[shadow_occ] = v;
            shadow_occ++;
          end else begin
            full = 1'b1;
            break;
          end
        end
        queue_beat('0, full ? ST_FULL : ST_OK, 1'b1);
      end
      REQ_POP, REQ_PEEK: begin
        if (shadow_occ == 0) begin
          queue_beat('0, ST_EMPTY, 1'b1);
        end else begin
          n = a ? shadow_occ : ((int'(c) > shadow_occ) ? shadow_occ : int'(c));
          if (n == 0) queue_beat('0, ST_OK, 1'b1);
          for (i = 0; i < n; i++) begin
            if (rq == REQ_POP) begin
              shadow_occ--;
              queue_beat(shadow_words[shadow_occ], ST_OK, i == n - 1);
            end else begin
              queue_beat(shadow_words[shadow_occ - 1 - i], ST_OK, i == n - 1);
            end
          end
        end
      end
      REQ_DEL: begin
        // scan from the bottom, drop the first matches, compact the rest
        quota = a ? shadow_occ : int'(c);
        removed = 0;
        dst = 0;
        for (i = 0; i < shadow_occ; i++) begin
          if (removed < quota && shadow_words[i] == v) begin
            removed++;
          end else begin
            shadow_words[dst] = shadow_words[i];
            dst++;
          end
        end
        shadow_occ = dst;
        queue_beat('0, ST_OK, 1'b1);
      end
      REQ_CLR: begin
        shadow_occ = 0;
        queue_beat('0, ST_OK, 1'b1);
      end
      default: queue_beat('0, ST_OK, 1'b1);
    endcase
    nres = pending_beats.size() - before_sz;
  endtask

  // drive one request beat, wait for acceptance, then predict it
  task automatic issue_request(input logic [REQ_W-1:0] rq, input logic signed [DATA_W-1:0] v,
                               input logic [OCC_W-1:0] c, input logic a, output int nres);
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= rq;
    value <= v;
    count <= c;
    all_flag <= a;
    do @(posedge clk); while (in_stall);
    model_request(rq, v, c, a, nres);
  endtask

  // random sender gap
  task automatic sender_gap();
    int g;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      g = $urandom_range(1, 13);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // hold off until every predicted beat has come back
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] wd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= wd;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_capacity_reg();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CAP_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(shadow_cap)) note_mismatch("capacity readback", prdata, shadow_cap);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(input int cap);
    apb_write(CAP_ADDR, 32'(cap));
    shadow_cap = cap;
    check_capacity_reg();
  endtask

  // receiver stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 99) < idle_pct / 4) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        note_mismatch("result beat with nothing expected, data", data, 0);
      end else begin
        got_beat = pending_beats.pop_front();
        if (data !== got_beat.data) note_mismatch("data", data, got_beat.data);
        if (status !== got_beat.status) note_mismatch("status", status, got_beat.status);
        if (in_use !== got_beat.in_use) note_mismatch("in_use", in_use, got_beat.in_use);
        if (last !== got_beat.last) note_mismatch("last", last, got_beat.last);
      end
    end
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("bounded_stack_with_bulk_ops verification failed");
    $finish;
  end

  // stimulus
  initial begin
    stim_row_t directed_rows [NUM_DIRECTED];
    stack_beat_t lit_beat;
    int phase_caps [NUM_PHASES];
    int phase_idle [NUM_PHASES];
    logic signed [DATA_W-1:0] word_pool [6];
    logic [REQ_W-1:0] rq;
    logic signed [DATA_W-1:0] v;
    logic [OCC_W-1:0] c;
    logic a;
    int nres, r, p, k, pick;

    directed_rows = '{
      '{REQ_POP,  32'sh0,        7'd1,  1'b0, 1'b1, ST_EMPTY, 7'd0},
      '{REQ_PEEK, 32'sh0,        7'd0,  1'b1, 1'b1, ST_EMPTY, 7'd0},
      '{REQ_DEL,  32'sh0,        7'd5,  1'b0, 1'b1, ST_OK,    7'd0},
      '{REQ_CLR,  32'sh0,        7'd0,  1'b0, 1'b1, ST_OK,    7'd0},
      '{REQ_PUSH, 32'sh7fffffff, 7'd0,  1'b0, 1'b1, ST_OK,    7'd0},
      '{REQ_PUSH, 32'sh7fffffff, 7'd3,  1'b0, 1'b1, ST_OK,    7'd3},
      '{REQ_PUSH, 32'sh80000000, 7'd2,  1'b0, 1'b1, ST_OK,    7'd5},
      '{REQ_PUSH, 32'shffffffff, 7'd4,  1'b0, 1'b1, ST_OK,    7'd9},
      '{REQ_PUSH, 32'sh0,        7'd1,  1'b1, 1'b1, ST_OK,    7'd10},
      '{REQ_PEEK, 32'sh0,        7'd0,  1'b0, 1'b1, ST_OK,    7'd10},
      '{REQ_PEEK, 32'sh0,        7'd3,  1'b0, 1'b0, ST_OK,    7'd0},
      '{REQ_PEEK, 32'sh0,        7'd64, 1'b0, 1'b0, ST_OK,    7'd0},
      '{REQ_PEEK, 32'sh0,        7'd1,  1'b1, 1'b0, ST_OK,    7'd0},
      '{REQ_POP,  32'sh0,        7'd2,  1'b0, 1'b0, ST_OK,    7'd0},
      '{REQ_DEL,  32'shffffffff, 7'd2,  1'b0, 1'b0, ST_OK,    7'd0},
      '{REQ_DEL,  32'shffffffff, 7'd0,  1'b1, 1'b0, ST_OK,    7'd0},
      '{REQ_DEL,  32'sh7fffffff, 7'd1,  1'b0, 1'b0, ST_OK,    7'd0},
      '{3'd5,     32'sh0,        7'd3,  1'b0, 1'b0, ST_OK,    7'd0},
      '{3'd6,     32'sh0,        7'd0,  1'b1, 1'b0, ST_OK,    7'd0},
      '{REQ_PUSH, 32'sh5555aaaa, 7'd64, 1'b0, 1'b1, ST_FULL,  7'd64},
      '{REQ_PUSH, 32'sh1,        7'd1,  1'b0, 1'b1, ST_FULL,  7'd64},
      '{REQ_POP,  32'sh0,        7'd0,  1'b1, 1'b0, ST_OK,    7'd0},
      '{REQ_POP,  32'sh0,        7'd3,  1'b0, 1'b1, ST_EMPTY, 7'd0},
      '{REQ_PUSH, 32'shaaaa5555, 7'd2,  1'b0, 1'b1, ST_OK,    7'd2},
      '{REQ_CLR,  32'sh0,        7'd9,  1'b1, 1'b1, ST_OK,    7'd0}
    };
    // large capacity first to build up entries, then zero and small ones below occupancy, then 40 and 64
    phase_caps = '{127, 0, 7, 1, 40, 64};
    phase_idle = '{30, 20, 0, 40, 15, 0};
    word_pool = '{32'sh0, 32'shffffffff, 32'sh7fffffff, 32'sh80000000,
                  32'sh12345678, 32'sha5a5a5a5};

    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_PUSH;
    value = '0;
    count = '0;
    all_flag = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    shadow_occ = 0;
    shadow_cap = int'(CAP_RESET);
    foreach (shadow_words[i]) shadow_words[i] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_capacity_reg();

    // directed table
    for (r = 0; r < NUM_DIRECTED; r++) begin
      issue_request(directed_rows[r].rq, directed_rows[r].v, directed_rows[r].c,
                    directed_rows[r].a, nres);
      if (directed_rows[r].lit) begin
        repeat (nres) void'(pending_beats.pop_back());
        lit_beat.data = '0;
        lit_beat.status = directed_rows[r].st;
        lit_beat.in_use = directed_rows[r].iu;
        lit_beat.last = 1'b1;
        pending_beats.push_back(lit_beat);
      end
      sender_gap();
    end

    // random phases, one capacity setting each
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      set_capacity(phase_caps[p]);
      idle_pct = phase_idle[p];
      quiet = (p == NUM_PHASES - 1);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 38) rq = REQ_PUSH;
        else if (pick < 58) rq = REQ_POP;
        else if (pick < 72) rq = REQ_DEL;
        else if (pick < 86) rq = REQ_PEEK;
        else if (pick < 92) rq = REQ_CLR;
        else rq = REQ_W'($urandom_range(5, 7));
        // repeated words so that delete finds matches
        if ($urandom_range(0, 99) < 70) v = word_pool[$urandom_range(0, 5)];
        else v = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 60) c = OCC_W'($urandom_range(0, 4));
        else if (pick < 90) c = OCC_W'($urandom_range(5, 16));
        else c = OCC_W'($urandom_range(17, 64));
        a = ($urandom_range(0, 99) < 20);
        issue_request(rq, v, c, a, nres);
        sender_gap();
      end
    end

    wait_drain();
    repeat (20) @(posedge clk);
    if (pending_beats.size() != 0)
      note_mismatch("results never delivered", pending_beats.size(), 0);
    if (mismatches == 0) begin
      $display("bounded_stack_with_bulk_ops verification clean");
    end else begin
      $display("bounded_stack_with_bulk_ops verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bstk_pkg.sv
rtl/bstk_ram.sv
rtl/bounded_stack_with_bulk_ops.sv
test/bounded_stack_with_bulk_ops_tb.sv
